// ----- hdl/ppg_beat_detector_macros.svh -----
// ============================================================================
// PPG beat detector assertion macros
// Shared property templates on the clk / arst_n pair of the including module.
// ============================================================================
`ifndef PPG_BEAT_DETECTOR_MACROS_SVH
`define PPG_BEAT_DETECTOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPGBD_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ppg_beat_detector: same-cycle property failed");

// The consequent must hold in the cycle after the antecedent.
`define PPGBD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ppg_beat_detector: next-cycle property failed");

`endif

// ----- hdl/ppgbd_pkg.sv -----
// ============================================================================
// PPG beat detector package
// Constants, filter coefficients and the controller command type.
// ============================================================================
package ppgbd_pkg;

	localparam int DELAY_DEPTH = 32;
	localparam int ADDR_W      = $clog2(DELAY_DEPTH);
	localparam int DC_SHIFT    = 4;
	localparam int DC_FRAC     = 15;
	localparam int TAP_PAIRS   = 11;
	localparam int CENTER_TAP  = TAP_PAIRS;
	localparam int NUM_TAPS    = TAP_PAIRS + 1;
	localparam int TAP_W       = $clog2(NUM_TAPS);
	localparam int FIR_SHIFT   = 15;
	localparam int COEF_W      = 14;

	typedef struct packed {
		logic             load;
		logic             write;
		logic             acc_clr;
		logic             rd_en;
		logic [TAP_W-1:0] tap;
		logic             mul_en;
		logic             acc_en;
		logic             finish;
	} ppgbd_cmd_t;

	function automatic logic signed [COEF_W-1:0] fir_coef(input logic [TAP_W-1:0] tap);
		logic signed [COEF_W-1:0] c;
		case (tap)
			4'd0:    c = 14'sd172;
			4'd1:    c = 14'sd321;
			4'd2:    c = 14'sd579;
			4'd3:    c = 14'sd927;
			4'd4:    c = 14'sd1360;
			4'd5:    c = 14'sd1858;
			4'd6:    c = 14'sd2390;
			4'd7:    c = 14'sd2916;
			4'd8:    c = 14'sd3391;
			4'd9:    c = 14'sd3768;
			4'd10:   c = 14'sd4012;
			4'd11:   c = 14'sd4096;
			default: c = 14'sd0;
		endcase
		return c;
	endfunction

endpackage

// ----- hdl/ppg_beat_detector.sv -----
// ============================================================================
// PPG beat detector
// Zero-crossing heart beat detection on raw optical samples.
// ============================================================================
// Each accepted beat carries one sample and yields exactly one result; a new
// beat is accepted only after the previous one has passed its finish step.
// The FIR filter sets the pace of that sequence: its twelve distinct
// taps are read one pair per cycle from the two-port delay line memory and fed
// through a single shared multiplier, after the DC update on acceptance and
// the delay line write, followed by the multiply and accumulate registers
// and the crossing state update. The result register lets the next beat be
// accepted while a result still waits. Limit writes are taken at any time but
// belong in idle periods.
// ============================================================================
`include "ppg_beat_detector_macros.svh"

module ppg_beat_detector
	import ppgbd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [15:0]        sample_value,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               beat_found,
	output logic signed [15:0] ac_signal,
	output logic [15:0]        dc_estimate
);

	localparam logic REG_LOW  = 1'b0;
	localparam logic REG_HIGH = 1'b1;

	logic [15:0] low_q;
	logic [15:0] high_q;
	ppgbd_cmd_t  cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= 16'd20;
			high_q <= 16'd1000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LOW:  low_q  <= cfg_data;
				REG_HIGH: high_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	ppgbd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	ppgbd_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sample_value (sample_value),
		.low_limit    (low_q),
		.high_limit   (high_q),
		.beat_found   (beat_found),
		.ac_signal    (ac_signal),
		.dc_estimate  (dc_estimate)
	);

	`PPGBD_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)
	`PPGBD_ASSERT_SAME(a_finish_has_room, cmd.finish, !out_valid || out_ready)
	`PPGBD_ASSERT_SAME(a_tap_in_range, cmd.rd_en, cmd.tap <= TAP_W'(CENTER_TAP))
	`PPGBD_ASSERT_SAME(a_beat_needs_window, out_valid && beat_found, low_q < high_q)

endmodule

// ----- hdl/ppgbd_ctrl.sv -----
// ============================================================================
// PPG beat detector controller
// Sequences DC update, delay line write, tap reads, multiply-accumulate and
// the result handoff for one beat at a time.
// ============================================================================
module ppgbd_ctrl
	import ppgbd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	output ppgbd_cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WRITE,
		ST_READ,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	localparam int DRAIN_CYCLES = 2;

	state_t           state_q;
	logic [TAP_W-1:0] cnt_q;
	logic             mul_q;
	logic             acc_q;
	logic             out_valid_q;
	logic             finish_ok;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign finish_ok = !out_valid_q || out_ready;

	always_comb begin
		cmd         = '0;
		cmd.load    = (state_q == ST_IDLE) && in_valid;
		cmd.write   = (state_q == ST_WRITE);
		cmd.acc_clr = (state_q == ST_WRITE);
		cmd.rd_en   = (state_q == ST_READ);
		cmd.tap     = cnt_q;
		cmd.mul_en  = mul_q;
		cmd.acc_en  = acc_q;
		cmd.finish  = (state_q == ST_FINISH) && finish_ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			mul_q       <= 1'b0;
			acc_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			mul_q <= (state_q == ST_READ);
			acc_q <= mul_q;
			if ((state_q == ST_FINISH) && finish_ok) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					cnt_q   <= '0;
					state_q <= ST_READ;
				end
				ST_READ: begin
					if (cnt_q == TAP_W'(NUM_TAPS - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_DRAIN;
					end else begin
						cnt_q <= cnt_q + TAP_W'(1);
					end
				end
				ST_DRAIN: begin
					if (cnt_q == TAP_W'(DRAIN_CYCLES - 1)) begin
						cnt_q   <= '0;
						state_q <= ST_FINISH;
					end else begin
						cnt_q <= cnt_q + TAP_W'(1);
					end
				end
				ST_FINISH: begin
					if (finish_ok) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- hdl/ppgbd_dp.sv -----
// ============================================================================
// PPG beat detector datapath
// DC tracker, delay line memory, shared FIR multiply-accumulate and the
// zero-crossing swing test with the result registers.
// ============================================================================
module ppgbd_dp
	import ppgbd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  ppgbd_cmd_t          cmd,
	input  logic [15:0]         sample_value,
	input  logic [15:0]         low_limit,
	input  logic [15:0]         high_limit,
	output logic                beat_found,
	output logic signed [15:0]  ac_signal,
	output logic [15:0]         dc_estimate
);

	logic [31:0]              dc_acc_q;
	logic [15:0]              sample_q;
	logic [ADDR_W-1:0]        widx_q;
	logic [DELAY_DEPTH-1:0]   fill_q;
	logic [15:0]              mem [DELAY_DEPTH];
	logic [15:0]              rd_a_s1;
	logic [15:0]              rd_b_s1;
	logic                     va_s1;
	logic                     vb_s1;
	logic [TAP_W-1:0]         tap_s1;
	logic signed [29:0]       prod_s2;
	logic signed [31:0]       fir_q;
	logic signed [15:0]       cur_ac_q;
	logic signed [15:0]       max_q;
	logic signed [15:0]       min_q;
	logic                     rise_q;
	logic                     fall_q;
	logic                     beat_q;
	logic signed [15:0]       ac_q;
	logic [15:0]              dc_q;

	logic signed [33:0]       dc_diff;
	logic signed [33:0]       dc_step;
	logic [31:0]              dc_next;
	logic [15:0]              est;
	logic [15:0]              tap_in;
	logic [ADDR_W-1:0]        addr_a;
	logic [ADDR_W-1:0]        addr_b;
	logic [15:0]              op_a;
	logic [15:0]              op_b;
	logic [15:0]              pair;
	logic signed [15:0]       operand;
	logic signed [COEF_W-1:0] coef;
	logic signed [29:0]       prod;
	logic signed [15:0]       cur;
	logic signed [15:0]       prev;
	logic                     rising;
	logic                     falling;
	logic signed [16:0]       swing;
	logic                     beat;
	logic                     rise_n;
	logic                     fall_n;
	logic signed [15:0]       max_n;
	logic signed [15:0]       min_n;

	assign dc_diff = $signed({3'b000, sample_value, 15'd0}) - $signed({{2{dc_acc_q[31]}}, dc_acc_q});
	assign dc_step = dc_diff >>> DC_SHIFT;
	assign dc_next = dc_acc_q + dc_step[31:0];
	assign est     = dc_acc_q[DC_FRAC+15:DC_FRAC];
	assign tap_in  = sample_q - est;

	assign addr_a = widx_q - ADDR_W'(cmd.tap);
	assign addr_b = widx_q + ADDR_W'(DELAY_DEPTH - 2 * TAP_PAIRS) + ADDR_W'(cmd.tap);

	assign op_a    = va_s1 ? rd_a_s1 : 16'd0;
	assign op_b    = vb_s1 ? rd_b_s1 : 16'd0;
	assign pair    = op_a + op_b;
	assign operand = (tap_s1 == TAP_W'(CENTER_TAP)) ? $signed(op_a) : $signed(pair);
	assign coef    = fir_coef(tap_s1);
	assign prod    = operand * coef;

	assign cur     = fir_q[FIR_SHIFT+15:FIR_SHIFT];
	assign prev    = cur_ac_q;
	assign rising  = (prev < 16'sd0) && (cur >= 16'sd0);
	assign falling = (prev > 16'sd0) && (cur <= 16'sd0);
	assign swing   = $signed({max_q[15], max_q}) - $signed({min_q[15], min_q});
	assign beat    = rising && (swing > $signed({1'b0, low_limit}))
		&& (swing < $signed({1'b0, high_limit}));

	always_comb begin
		rise_n = rise_q;
		fall_n = fall_q;
		max_n  = max_q;
		min_n  = min_q;
		if (rising) begin
			rise_n = 1'b1;
			fall_n = 1'b0;
			max_n  = 16'sd0;
		end
		if (falling) begin
			rise_n = 1'b0;
			fall_n = 1'b1;
			min_n  = 16'sd0;
		end
		if (rise_n && (cur > prev)) begin
			max_n = cur;
		end
		if (fall_n && (cur < prev)) begin
			min_n = cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dc_acc_q <= '0;
			widx_q   <= '0;
			fill_q   <= '0;
			cur_ac_q <= '0;
			max_q    <= '0;
			min_q    <= '0;
			rise_q   <= 1'b0;
			fall_q   <= 1'b0;
		end else begin
			if (cmd.load) begin
				dc_acc_q <= dc_next;
			end
			if (cmd.write) begin
				fill_q[widx_q] <= 1'b1;
			end
			if (cmd.finish) begin
				widx_q   <= widx_q + ADDR_W'(1);
				cur_ac_q <= cur;
				max_q    <= max_n;
				min_q    <= min_n;
				rise_q   <= rise_n;
				fall_q   <= fall_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= sample_value;
		end
		if (cmd.write) begin
			mem[widx_q] <= tap_in;
		end
		if (cmd.rd_en) begin
			rd_a_s1 <= mem[addr_a];
			rd_b_s1 <= mem[addr_b];
			va_s1   <= fill_q[addr_a];
			vb_s1   <= fill_q[addr_b];
			tap_s1  <= cmd.tap;
		end
		if (cmd.mul_en) begin
			prod_s2 <= prod;
		end
		if (cmd.acc_clr) begin
			fir_q <= '0;
		end else if (cmd.acc_en) begin
			fir_q <= fir_q + $signed({{2{prod_s2[29]}}, prod_s2});
		end
		if (cmd.finish) begin
			beat_q <= beat;
			ac_q   <= cur;
			dc_q   <= est;
		end
	end

	assign beat_found  = beat_q;
	assign ac_signal   = ac_q;
	assign dc_estimate = dc_q;

endmodule
